// File: hw/rtl/rls_adaptive_estimator_assert.svh
// Assertion macros for the recursive least squares estimator.
// Used by rls_adaptive_estimator.sv; needs clk and rst_n in scope.
`ifndef RLS_ADAPTIVE_ESTIMATOR_ASSERT_SVH
`define RLS_ADAPTIVE_ESTIMATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define RLS_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rls assertion failed");
// Next-cycle implication checked outside reset.
`define RLS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rls assertion failed");
`endif

// File: hw/rtl/rls_pkg.sv
// Package for the recursive least squares estimator.
// Holds command codes, fixed-point widths and shared constants; no dependencies.
`timescale 1ns / 1ps
package rls_pkg;
  localparam int SigW = 32;
  localparam int PW = 48;
  localparam int LamW = 17;
  localparam int LamFrac = 16;
  localparam int ClampExp = 58;

  typedef enum logic [1:0] {
    CMD_REGRESSOR = 2'd0,
    CMD_WEIGHT    = 2'd1,
    CMD_RESTART   = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_t;
endpackage

// File: hw/rtl/rls_adaptive_estimator.sv
// Exponentially weighted recursive least squares estimator, top level.
// Depends on rls_pkg and rls_adaptive_estimator_assert.svh.
//
// Regressor elements arrive one per item, the desired value with the last one.
// A regressor item that completes the vector runs one update through a single
// shared 64x64 magnitude multiplier (split into four 32x32 partial products,
// one per cycle) and a shared bit-serial divider (one quotient bit per cycle).
// The update makes 2*N*N+3N products plus N*N divisions, and N more divisions
// when the gain denominator is positive; then N results are shown, one per
// accepted output. P sits in a memory of N*N entries; restart and reset sweep
// it to identity, and no item is accepted during the sweep.
`timescale 1ns / 1ps
`include "rls_adaptive_estimator_assert.svh"
module rls_adaptive_estimator #(
  parameter int VECTOR_LENGTH = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [rls_pkg::LamW-1:0]   cfg_forgetting_factor,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_cmd,
  input  logic signed [31:0]         in_value,
  input  logic signed [31:0]         in_desired,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_weight_index,
  output logic signed [31:0]         out_weight_value,
  output logic signed [31:0]         out_estimate,
  output logic signed [31:0]         out_error,
  output logic                       out_saturated,
  output logic                       out_last
);
  localparam int N = VECTOR_LENGTH;
  localparam int IW = (N > 1) ? $clog2(N) : 1;
  localparam int CW = $clog2(N + 1);
  localparam int MW = $clog2(N * N + 1);
  localparam int AW = (N * N > 1) ? $clog2(N * N) : 1;
  localparam int PF = 2 * FRAC_BITS;
  localparam int SW = rls_pkg::SigW;
  localparam int PW = rls_pkg::PW;
  localparam int DCW = 8;

  localparam logic [63:0] CLAMP = 64'd1 << rls_pkg::ClampExp;
  localparam logic signed [PW-1:0] P_ONE = PW'(64'sd1 <<< PF);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE,
    S_PI_RD, S_PI_MUL, S_PI_ACC,
    S_GA_MUL, S_GA_ACC,
    S_K_DIV, S_K_WR,
    S_ES_MUL, S_ES_ACC,
    S_W_MUL, S_W_WR,
    S_P_RD, S_P_MUL, S_P_DIV, S_P_WR,
    S_OUT
  } state_t;

  state_t state_r;
  logic [MW-1:0] clr_r;
  logic [MW-1:0] diag_r;
  logic [CW-1:0] cnt_r;
  logic [IW-1:0] i_r, j_r;
  logic [rls_pkg::LamW-1:0] lam_r;
  logic signed [SW-1:0] w_r [N];
  logic signed [SW-1:0] u_r [N];
  logic signed [PW-1:0] k_r [N];
  logic signed [PW-1:0] pi_r [N];
  logic signed [PW-1:0] p_mem [N*N];
  logic signed [PW-1:0] p_rd_r;
  logic signed [63:0] acc_r;
  logic signed [SW-1:0] des_r, est_r, err_r;
  logic sat_r;

  // shared multiplier: |a|*|b| as four 32x32 partial products, then shift and clamp
  logic signed [63:0] ma_r, mb_r;
  logic [63:0] mx_r, my_r;
  logic [127:0] mprod_r;
  logic [2:0] mph_r;
  logic mneg_r;
  logic [6:0] msh_r;

  // shared divider: restoring, one bit per cycle
  logic [63:0] dn_r, dd_r, dr_r, dq_r;
  logic [DCW-1:0] dt_r, dtot_r;
  logic [6:0] dsh_r;
  logic dbig_r, dneg_r;

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    mag = v[63] ? 64'(-v) : 64'(v);
  endfunction

  logic [31:0] mop_a, mop_b;
  logic [63:0] mpp;
  logic [6:0] mpsh;
  always_comb begin
    case (mph_r)
      3'd1: begin mop_a = mx_r[31:0]; mop_b = my_r[31:0]; mpsh = 7'd0; end
      3'd2: begin mop_a = mx_r[31:0]; mop_b = my_r[63:32]; mpsh = 7'd32; end
      3'd3: begin mop_a = mx_r[63:32]; mop_b = my_r[31:0]; mpsh = 7'd32; end
      3'd4: begin mop_a = mx_r[63:32]; mop_b = my_r[63:32]; mpsh = 7'd64; end
      default: begin mop_a = '0; mop_b = '0; mpsh = 7'd0; end
    endcase
    mpp = mop_a * mop_b;
  end

  logic [63:0] mshifted;
  logic signed [63:0] mres;
  always_comb begin
    logic [127:0] t;
    t = mprod_r >> msh_r;
    if (t[127:64] != 64'd0 || t[63:0] > CLAMP) mshifted = CLAMP;
    else mshifted = t[63:0];
    mres = mneg_r ? -$signed(mshifted) : $signed(mshifted);
  end

  logic [63:0] dres_mag;
  logic signed [63:0] dres;
  always_comb begin
    dres_mag = (dbig_r || dq_r > CLAMP) ? CLAMP : dq_r;
    dres = dneg_r ? -$signed(dres_mag) : $signed(dres_mag);
  end

  function automatic logic signed [63:0] satv(input logic signed [63:0] v, input int bits,
                                              output logic s);
    logic signed [63:0] hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    s = 1'b0;
    satv = v;
    if (v > hi) begin s = 1'b1; satv = hi; end
    else if (v < lo) begin s = 1'b1; satv = lo; end
  endfunction

  logic signed [63:0] lam_s;
  assign lam_s = (lam_r == '0) ? 64'sd1 : $signed({47'd0, lam_r});

  logic [AW-1:0] p_idx;
  assign p_idx = AW'(int'(i_r) * N + int'(j_r));

  logic in_acc, out_acc;
  assign in_ready = (state_r == S_IDLE);
  assign in_acc = in_valid && in_ready;
  assign out_valid = (state_r == S_OUT);
  assign out_acc = out_valid && out_ready;
  assign out_weight_index = 3'(i_r);
  assign out_weight_value = w_r[i_r];
  assign out_estimate = est_r;
  assign out_error = err_r;
  assign out_saturated = sat_r;
  assign out_last = (int'(i_r) == N - 1);

  logic p_we;
  logic [AW-1:0] p_wa;
  logic signed [PW-1:0] p_wd;

  always_ff @(posedge clk) begin
    if (p_we) p_mem[p_wa] <= p_wd;
    p_rd_r <= p_mem[p_idx];
  end

  always_comb begin
    p_we = 1'b0;
    p_wa = p_idx;
    p_wd = '0;
    if (state_r == S_CLEAR) begin
      p_we = 1'b1;
      p_wa = AW'(clr_r);
      p_wd = (clr_r == diag_r) ? P_ONE : '0;
    end else if (state_r == S_P_WR) begin
      p_we = 1'b1;
      p_wd = PW'(acc_r);
    end
  end

  always_ff @(posedge clk) begin
    logic s;
    logic signed [63:0] v;
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      diag_r <= '0;
      cnt_r <= '0;
      i_r <= '0;
      j_r <= '0;
      lam_r <= rls_pkg::LamW'(65536);
      mph_r <= '0;
      dt_r <= '0;
      for (int n = 0; n < N; n++) w_r[n] <= '0;
    end else begin
      if (cfg_we) lam_r <= cfg_forgetting_factor;
      // multiplier phases
      if (mph_r != 3'd0) begin
        mprod_r <= mprod_r + (128'(mpp) << mpsh);
        mph_r <= (mph_r == 3'd4) ? 3'd0 : mph_r + 3'd1;
      end
      // divider step
      if (dt_r != 8'd0) begin
        logic [63:0] r2, q2;
        logic b;
        logic [DCW-1:0] idx;
        idx = dtot_r - dt_r;
        idx = DCW'(63) + DCW'(dsh_r) - idx;
        b = (idx >= DCW'(dsh_r)) ? dn_r[6'(idx - DCW'(dsh_r))] : 1'b0;
        r2 = {dr_r[62:0], b};
        q2 = dq_r;
        if (q2 > CLAMP) dbig_r <= 1'b1; else q2 = q2 << 1;
        if (r2 >= dd_r) begin
          r2 = r2 - dd_r;
          if (!(dbig_r || dq_r > CLAMP)) q2[0] = 1'b1;
        end
        dr_r <= r2;
        dq_r <= q2;
        dt_r <= dt_r - 8'd1;
      end
      case (state_r)
        S_CLEAR: begin
          if (int'(clr_r) == N * N - 1) begin
            clr_r <= '0;
            diag_r <= '0;
            state_r <= S_IDLE;
          end else begin
            clr_r <= clr_r + MW'(1);
            if (clr_r == diag_r) diag_r <= diag_r + MW'(N + 1);
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            case (rls_pkg::cmd_t'(in_cmd))
              rls_pkg::CMD_RESTART: begin
                for (int n = 0; n < N; n++) w_r[n] <= '0;
                cnt_r <= '0;
                state_r <= S_CLEAR;
              end
              rls_pkg::CMD_WEIGHT: begin
                w_r[IW'(cnt_r)] <= in_value;
                cnt_r <= (int'(cnt_r) == N - 1) ? '0 : cnt_r + CW'(1);
              end
              rls_pkg::CMD_REGRESSOR: begin
                u_r[IW'(cnt_r)] <= in_value;
                des_r <= in_desired;
                if (int'(cnt_r) == N - 1) begin
                  cnt_r <= '0;
                  sat_r <= 1'b0;
                  i_r <= '0;
                  j_r <= '0;
                  acc_r <= '0;
                  state_r <= S_PI_RD;
                end else begin
                  cnt_r <= cnt_r + CW'(1);
                end
              end
              default: ;
            endcase
          end
        end
        // pi[j] = sum_i u[i]*P[i][j] >> F
        S_PI_RD: state_r <= S_PI_MUL;
        S_PI_MUL: begin
          mx_r <= mag(64'(u_r[i_r]));
          my_r <= mag(64'(p_rd_r));
          mneg_r <= u_r[i_r][SW-1] ^ p_rd_r[PW-1];
          msh_r <= 7'(FRAC_BITS);
          mprod_r <= '0;
          mph_r <= 3'd1;
          state_r <= S_PI_ACC;
        end
        S_PI_ACC: if (mph_r == 3'd0) begin
          if (int'(i_r) == N - 1) begin
            v = satv(acc_r + mres, PW, s);
            pi_r[j_r] <= PW'(v);
            sat_r <= sat_r | s;
            i_r <= '0;
            if (int'(j_r) == N - 1) begin
              j_r <= '0;
              acc_r <= lam_s <<< (PF - rls_pkg::LamFrac);
              state_r <= S_GA_MUL;
            end else begin
              j_r <= j_r + IW'(1);
              acc_r <= '0;
              state_r <= S_PI_RD;
            end
          end else begin
            acc_r <= acc_r + mres;
            i_r <= i_r + IW'(1);
            state_r <= S_PI_RD;
          end
        end
        S_GA_MUL: begin
          mx_r <= mag(64'(pi_r[j_r]));
          my_r <= mag(64'(u_r[j_r]));
          mneg_r <= pi_r[j_r][PW-1] ^ u_r[j_r][SW-1];
          msh_r <= 7'(FRAC_BITS);
          mprod_r <= '0;
          mph_r <= 3'd1;
          state_r <= S_GA_ACC;
        end
        S_GA_ACC: if (mph_r == 3'd0) begin
          if (int'(j_r) == N - 1) begin
            v = satv(acc_r + mres, PW, s);
            acc_r <= v;
            sat_r <= sat_r | s | (v <= 0);
            j_r <= '0;
            i_r <= '0;
            if (v > 0) begin
              dd_r <= 64'(v);
              dn_r <= mag(64'(pi_r[0]));
              dneg_r <= pi_r[0][PW-1];
              dsh_r <= 7'(PF);
              dtot_r <= DCW'(64 + PF);
              dt_r <= DCW'(64 + PF);
              dr_r <= '0; dq_r <= '0; dbig_r <= 1'b0;
              state_r <= S_K_DIV;
            end else begin
              for (int n = 0; n < N; n++) k_r[n] <= '0;
              acc_r <= '0;
              state_r <= S_ES_MUL;
            end
          end else begin
            acc_r <= acc_r + mres;
            j_r <= j_r + IW'(1);
            state_r <= S_GA_MUL;
          end
        end
        S_K_DIV: if (dt_r == '0) state_r <= S_K_WR;
        S_K_WR: begin
          v = satv(dres, PW, s);
          k_r[i_r] <= PW'(v);
          sat_r <= sat_r | s;
          if (int'(i_r) == N - 1) begin
            i_r <= '0;
            acc_r <= '0;
            state_r <= S_ES_MUL;
          end else begin
            i_r <= i_r + IW'(1);
            dn_r <= mag(64'(pi_r[i_r + IW'(1)]));
            dneg_r <= pi_r[i_r + IW'(1)][PW-1];
            dt_r <= dtot_r;
            dr_r <= '0; dq_r <= '0; dbig_r <= 1'b0;
            state_r <= S_K_DIV;
          end
        end
        S_ES_MUL: begin
          mx_r <= mag(64'(w_r[i_r]));
          my_r <= mag(64'(u_r[i_r]));
          mneg_r <= w_r[i_r][SW-1] ^ u_r[i_r][SW-1];
          msh_r <= 7'(FRAC_BITS);
          mprod_r <= '0;
          mph_r <= 3'd1;
          state_r <= S_ES_ACC;
        end
        S_ES_ACC: if (mph_r == 3'd0) begin
          if (int'(i_r) == N - 1) begin
            logic s2;
            logic signed [63:0] e;
            v = satv(acc_r + mres, SW, s);
            e = satv(64'(des_r) - v, SW, s2);
            est_r <= SW'(v);
            err_r <= SW'(e);
            sat_r <= sat_r | s | s2;
            i_r <= '0;
            state_r <= S_W_MUL;
          end else begin
            acc_r <= acc_r + mres;
            i_r <= i_r + IW'(1);
            state_r <= S_ES_MUL;
          end
        end
        S_W_MUL: begin
          mx_r <= mag(64'(k_r[i_r]));
          my_r <= mag(64'(err_r));
          mneg_r <= k_r[i_r][PW-1] ^ err_r[SW-1];
          msh_r <= 7'(PF);
          mprod_r <= '0;
          mph_r <= 3'd1;
          state_r <= S_W_WR;
        end
        S_W_WR: if (mph_r == 3'd0) begin
          v = satv(64'(w_r[i_r]) + mres, SW, s);
          w_r[i_r] <= SW'(v);
          sat_r <= sat_r | s;
          if (int'(i_r) == N - 1) begin
            i_r <= '0;
            j_r <= '0;
            acc_r <= '0;
            state_r <= S_P_RD;
          end else begin
            i_r <= i_r + IW'(1);
            state_r <= S_W_MUL;
          end
        end
        S_P_RD: state_r <= S_P_MUL;
        S_P_MUL: begin
          mx_r <= mag(64'(k_r[i_r]));
          my_r <= mag(64'(pi_r[j_r]));
          mneg_r <= k_r[i_r][PW-1] ^ pi_r[j_r][PW-1];
          msh_r <= 7'(PF);
          mprod_r <= '0;
          mph_r <= 3'd1;
          state_r <= S_P_DIV;
        end
        S_P_DIV: begin
          if (mph_r == 3'd0 && dt_r == '0 && acc_r != 64'sd1) begin
            logic signed [63:0] diff;
            diff = 64'(p_rd_r) - mres;
            dn_r <= mag(diff);
            dneg_r <= diff[63];
            dd_r <= 64'(lam_s);
            dsh_r <= 7'(rls_pkg::LamFrac);
            dtot_r <= DCW'(64 + rls_pkg::LamFrac);
            dt_r <= DCW'(64 + rls_pkg::LamFrac);
            dr_r <= '0; dq_r <= '0; dbig_r <= 1'b0;
            acc_r <= 64'sd1;
          end else if (acc_r == 64'sd1 && dt_r == '0) begin
            v = satv(dres, PW, s);
            acc_r <= v;
            sat_r <= sat_r | s;
            state_r <= S_P_WR;
          end
        end
        S_P_WR: begin
          acc_r <= '0;
          if (int'(j_r) == N - 1) begin
            j_r <= '0;
            if (int'(i_r) == N - 1) begin
              i_r <= '0;
              state_r <= S_OUT;
            end else begin
              i_r <= i_r + IW'(1);
              state_r <= S_P_RD;
            end
          end else begin
            j_r <= j_r + IW'(1);
            state_r <= S_P_RD;
          end
        end
        S_OUT: if (out_acc) begin
          if (int'(i_r) == N - 1) begin
            i_r <= '0;
            state_r <= S_IDLE;
          end else begin
            i_r <= i_r + IW'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `RLS_ASSERT_IMPL(a_no_overlap, in_ready, !out_valid)
  `RLS_ASSERT_IMPL(a_cnt_range, 1'b1, int'(cnt_r) < N)
  `RLS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_weight_index))
endmodule
